### hw/rtl/rbb_pkg.sv
// Shared types, register codes and rounding helper for the rotated bounding box.
`default_nettype none

package rbb_pkg;

	localparam int unsigned CfgIdxW = 2;
	localparam logic [31:0] CosReset = 32'h4000_0000;
	localparam logic [31:0] SinReset = 32'h0000_0000;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_COS = 2'd0,
		CFG_SIN = 2'd1
	} rbb_cfg_idx_t;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic               last_point;
	} rbb_point_t;

	typedef struct packed {
		logic signed [31:0] box_min_x;
		logic signed [31:0] box_min_y;
		logic signed [31:0] box_max_x;
		logic signed [31:0] box_max_y;
	} rbb_box_t;

	// Scale a Q35.30 product sum by 2^-30, round half away from zero, saturate to 32 bits.
	function automatic logic signed [31:0] rbb_round_sat(input logic signed [64:0] sum);
		logic [64:0] mag;
		logic [64:0] biased;
		logic [34:0] q;
		logic [31:0] r;
		mag    = sum[64] ? (~sum + 65'd1) : sum;
		biased = mag + (65'd1 << 29);
		q      = biased[64:30];
		if (sum[64]) begin
			r = (q > 35'h0_8000_0000) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
		end else begin
			r = (q > 35'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/rbb_rotate.sv
// Rotation pipeline: products, product sums, then rounding and saturation.
`default_nettype none

module rbb_rotate (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic signed [31:0]  cos_q,
	input  wire logic signed [31:0]  sin_q,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire rbb_pkg::rbb_point_t in_pt,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic signed [31:0]       out_rx,
	output logic signed [31:0]       out_ry,
	output logic                     out_last
);
	import rbb_pkg::*;

	logic               v_s2, v_s3, v_s4;
	logic               rdy_s2, rdy_s3, rdy_s4;
	logic signed [63:0] cx_s2, sy_s2, cy_s2, sx_s2;
	logic               last_s2, last_s3, last_s4;
	logic signed [64:0] sumx_s3, sumy_s3;
	logic signed [31:0] rx_s4, ry_s4;

	// A stage loads when it is empty or its content moves on.
	assign rdy_s4   = !v_s4 || out_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign in_ready = rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s2) v_s2 <= in_valid;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && in_valid) begin
			cx_s2   <= cos_q * in_pt.px;
			sy_s2   <= sin_q * in_pt.py;
			cy_s2   <= cos_q * in_pt.py;
			sx_s2   <= sin_q * in_pt.px;
			last_s2 <= in_pt.last_point;
		end
		if (rdy_s3 && v_s2) begin
			sumx_s3 <= $signed({cx_s2[63], cx_s2}) - $signed({sy_s2[63], sy_s2});
			sumy_s3 <= $signed({cy_s2[63], cy_s2}) + $signed({sx_s2[63], sx_s2});
			last_s3 <= last_s2;
		end
		if (rdy_s4 && v_s3) begin
			rx_s4   <= rbb_round_sat(sumx_s3);
			ry_s4   <= rbb_round_sat(sumy_s3);
			last_s4 <= last_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_rx    = rx_s4;
	assign out_ry    = ry_s4;
	assign out_last  = last_s4;

endmodule

`default_nettype wire

### hw/rtl/rbb_fold.sv
// Running min/max box and the result register.
`default_nettype none

module rbb_fold (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [31:0] in_rx,
	input  wire logic signed [31:0] in_ry,
	input  wire logic               in_last,
	output logic                    box_valid,
	input  wire logic               box_stall,
	output rbb_pkg::rbb_box_t       box
);
	import rbb_pkg::*;

	logic              started_q;
	logic              box_valid_q;
	rbb_box_t          run_q;
	rbb_box_t          box_q;
	rbb_box_t          next_box;
	logic              acc;
	logic              taken;

	// Only a last point needs the result register.
	assign taken    = box_valid_q && !box_stall;
	assign in_ready = !in_last || !box_valid_q || !box_stall;
	assign acc      = in_valid && in_ready;

	always_comb begin
		if (!started_q) begin
			next_box.box_min_x = in_rx;
			next_box.box_max_x = in_rx;
			next_box.box_min_y = in_ry;
			next_box.box_max_y = in_ry;
		end else begin
			next_box.box_min_x = (in_rx < run_q.box_min_x) ? in_rx : run_q.box_min_x;
			next_box.box_max_x = (in_rx > run_q.box_max_x) ? in_rx : run_q.box_max_x;
			next_box.box_min_y = (in_ry < run_q.box_min_y) ? in_ry : run_q.box_min_y;
			next_box.box_max_y = (in_ry > run_q.box_max_y) ? in_ry : run_q.box_max_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			box_valid_q <= 1'b0;
		end else begin
			if (acc) started_q <= !in_last;
			if (acc && in_last) begin
				box_valid_q <= 1'b1;
			end else if (taken) begin
				box_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) run_q <= next_box;
		if (acc && in_last) box_q <= next_box;
	end

	assign box_valid = box_valid_q;
	assign box       = box_q;

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		acc && in_last |=> box_valid_q)
		else $error("last point did not load the result register");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc && in_last |=> !started_q)
		else $error("box not cleared after a last point");

	a_mid_starts: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !in_last |=> started_q)
		else $error("box not started after a point");

	a_box_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid_q |-> (box_q.box_min_x <= box_q.box_max_x) &&
		(box_q.box_min_y <= box_q.box_max_y))
		else $error("emitted box has min above max");

endmodule

`default_nettype wire

### hw/rtl/rotated_bounding_box.sv
// Top level of the rotated bounding box: config registers, input register, pipeline.
`default_nettype none

// Rotated bounding box. Each point request (px, py, last_point) is rotated by the
// angle held in cos_q/sin_q (signed Q2.30; reset 1.0 and 0): x' = c*px - s*py,
// y' = c*py + s*px, each scaled by 2^-30, rounded half away from zero and
// saturated to signed 32 bits. A running min/max box is kept per set; the first
// point of a set seeds it, and the point marked last_point sends the box out on
// the box channel and starts a fresh set. Points that are not last give no
// request on the box channel. The block takes one point every cycle while pt_stall
// is low; after a last point is accepted it passes through the input register,
// the product stage, sum stage and rounding stage, and its box is then loaded
// into the box register. The single box register is the only place that holds
// the stream back: a point stalls only while the pipeline is full behind a last
// point whose box register is still occupied. Write cos_q (index 0) and sin_q
// (index 1) only while no point is in flight; other indexes are ignored.
module rotated_bounding_box (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [rbb_pkg::CfgIdxW-1:0]      cfg_index,
	input  wire logic [31:0]                      cfg_wdata,
	input  wire logic                             pt_valid,
	output logic                                  pt_stall,
	input  wire rbb_pkg::rbb_point_t              pt,
	output logic                                  box_valid,
	input  wire logic                             box_stall,
	output rbb_pkg::rbb_box_t                     box
);
	import rbb_pkg::*;

	logic signed [31:0] cos_q, sin_q;
	logic               v_s1;
	logic               rdy_s1;
	rbb_point_t         pt_s1;
	logic               rot_ready;
	logic               rot_valid;
	logic signed [31:0] rot_rx, rot_ry;
	logic               rot_last;
	logic               fold_ready;

	// Config registers: take a write only at a known index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q <= CosReset;
			sin_q <= SinReset;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COS: cos_q <= cfg_wdata;
				CFG_SIN: sin_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input register: load whenever empty or its point moves into the multipliers.
	assign rdy_s1   = !v_s1 || rot_ready;
	assign pt_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= pt_valid;
		end
	end

	// Hold the payload while stalled; advance with the request.
	always_ff @(posedge clk) begin
		if (rdy_s1 && pt_valid) pt_s1 <= pt;
	end

	rbb_rotate u_rotate (
		.clk       (clk),
		.arst_n    (arst_n),
		.cos_q     (cos_q),
		.sin_q     (sin_q),
		.in_valid  (v_s1),
		.in_ready  (rot_ready),
		.in_pt     (pt_s1),
		.out_valid (rot_valid),
		.out_ready (fold_ready),
		.out_rx    (rot_rx),
		.out_ry    (rot_ry),
		.out_last  (rot_last)
	);

	// Fold the rotated point into the box; drop nothing, emit on the last point.
	rbb_fold u_fold (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rot_valid),
		.in_ready  (fold_ready),
		.in_rx     (rot_rx),
		.in_ry     (rot_ry),
		.in_last   (rot_last),
		.box_valid (box_valid),
		.box_stall (box_stall),
		.box       (box)
	);

endmodule

`default_nettype wire
